/* src/mpes_pkg.sv */
// ============================================================================
// mpes_pkg
// Shared widths, payload structs and controller/datapath command types for
// the multi-period event scheduler.
// ============================================================================
package mpes_pkg;

    // Field widths
    localparam int DATA_W    = 32;
    localparam int TIME_W    = 48;
    localparam int MASK_W    = 4;

    // Configuration: one period register per addressable channel
    localparam int NUM_REGS  = 4;
    localparam int CFG_IDX_W = 2;

    // Default channel count
    localparam int CHANNELS_DEF = 4;

    // Operation codes
    localparam logic OP_PASS   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // Input transaction payload
    typedef struct packed {
        logic              opcode;
        logic [DATA_W-1:0] busy_time;
    } in_item_t;

    // Output transaction payload
    typedef struct packed {
        logic [MASK_W-1:0] fire_mask;
        logic [DATA_W-1:0] next_due;
        logic [DATA_W-1:0] advance;
        logic [TIME_W-1:0] now_time;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_in;    // capture input transaction
        logic resync;     // reload accumulators from periods
        logic clear;      // start a pass: channel 0, clear mask and minimum
        logic mod_start;  // load remainder unit with current accumulator
        logic mod_step;   // one restoring step of the remainder unit
        logic eval_acc;   // fold p - acc of current channel into minimum
        logic eval_rem;   // write back remainder, fire, fold p - rem
        logic step_ch;    // advance channel counter (wraps after last)
        logic calc_adv;   // pick advance amount
        logic add_ch;     // saturating add on current channel
        logic add_time;   // advance time counter
        logic load_out;   // move result into output register
    } dp_cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic opcode;     // captured opcode
        logic active;     // current channel has nonzero period
        logic due;        // current accumulator reached its period
        logic mod_last;   // final remainder step
        logic ch_last;    // current channel is the last one
    } dp_stat_t;

endpackage

/* src/mpes_ctrl.sv */
// ============================================================================
// mpes_ctrl
// Sequencing state machine: walks the channels, drives the remainder unit,
// and owns the input/output handshake flags.
// ============================================================================
module mpes_ctrl
    import mpes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_REM   = 3'd4;
    localparam logic [2:0] S_ADV   = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (stat.opcode == OP_RESYNC)
                begin
                    cmd.resync = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.active && stat.due)
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_MOD;
                end
                else
                begin
                    cmd.eval_acc = stat.active;
                    cmd.step_ch  = 1'b1;
                    state_next   = stat.ch_last ? S_ADV : S_CHECK;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                    state_next = S_REM;
            end
            S_REM:
            begin
                cmd.eval_rem = 1'b1;
                cmd.step_ch  = 1'b1;
                state_next   = stat.ch_last ? S_ADV : S_CHECK;
            end
            S_ADV:
            begin
                cmd.calc_adv = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_ch  = 1'b1;
                cmd.step_ch = 1'b1;
                if (stat.ch_last)
                begin
                    cmd.add_time = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* src/mpes_dp.sv */
// ============================================================================
// mpes_dp
// Datapath: period registers, per-channel accumulators, a bit-serial
// remainder unit, minimum tracking, time counter and output register.
// ============================================================================
module mpes_dp
    import mpes_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_item_t             in_data,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int BIT_W = $clog2(DATA_W);

    logic [DATA_W-1:0] period_reg [NUM_REGS];
    logic [DATA_W-1:0] acc_reg    [CHANNELS];
    logic [DATA_W-1:0] acc_next   [CHANNELS];
    logic [DATA_W-1:0] chan_per   [CHANNELS];

    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [DATA_W-1:0] min_reg, min_next;
    logic              any_reg, any_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [DATA_W-1:0] adv_reg, adv_next;
    logic [DATA_W-1:0] busy_reg, busy_next;
    logic              op_reg, op_next;
    logic [TIME_W-1:0] time_reg, time_next;
    out_item_t         out_reg, out_next;

    logic [DATA_W-1:0] cur_per;
    logic [DATA_W-1:0] cur_acc;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   sat_sum;
    logic [DATA_W-1:0] left_val;
    logic              resync_any;

    // Channel periods: channels without a register stay disabled
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_per
        if (g < NUM_REGS)
        begin : g_reg
            assign chan_per[g] = period_reg[g];
        end
        else
        begin : g_off
            assign chan_per[g] = '0;
        end
    end

    assign cur_per = chan_per[ch_reg];
    assign cur_acc = acc_reg[ch_reg];

    // Restoring remainder step
    assign trial = {rem_reg, dvd_reg[DATA_W-1]};

    // Time left for the current channel, from accumulator or fresh remainder
    assign left_val = cur_per - (cmd.eval_rem ? rem_reg : cur_acc);

    // Saturating add for the advance phase
    assign sat_sum = {1'b0, cur_acc} + {1'b0, adv_reg};

    always_comb
    begin
        resync_any = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
            if (chan_per[i] != '0)
                resync_any = 1'b1;
    end

    // Status to controller
    assign stat.opcode   = op_reg;
    assign stat.active   = (cur_per != '0);
    assign stat.due      = (cur_acc >= cur_per);
    assign stat.mod_last = (bit_reg == BIT_W'(DATA_W-1));
    assign stat.ch_last  = (ch_reg == CH_W'(CHANNELS-1));

    assign out_data = out_reg;

    // Next-state logic
    always_comb
    begin
        ch_next   = ch_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        bit_next  = bit_reg;
        min_next  = min_reg;
        any_next  = any_reg;
        mask_next = mask_reg;
        adv_next  = adv_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        time_next = time_reg;
        out_next  = out_reg;
        for (int i = 0; i < CHANNELS; i++)
            acc_next[i] = acc_reg[i];

        if (cmd.take_in)
        begin
            op_next   = in_data.opcode;
            busy_next = in_data.busy_time;
        end

        // Resync: every accumulator reloads its period
        if (cmd.resync)
        begin
            for (int i = 0; i < CHANNELS; i++)
                acc_next[i] = chan_per[i];
            mask_next = '0;
            adv_next  = '0;
            min_next  = resync_any ? '0 : '1;
        end

        if (cmd.clear)
        begin
            ch_next   = '0;
            mask_next = '0;
            min_next  = '1;
            any_next  = 1'b0;
        end

        // Remainder unit
        if (cmd.mod_start)
        begin
            rem_next = '0;
            dvd_next = cur_acc;
            bit_next = '0;
        end
        if (cmd.mod_step)
        begin
            if (trial >= {1'b0, cur_per})
                rem_next = DATA_W'(trial - {1'b0, cur_per});
            else
                rem_next = trial[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            bit_next = bit_reg + 1'b1;
        end

        // Fold time-to-due of current channel into minimum
        if (cmd.eval_acc || cmd.eval_rem)
        begin
            any_next = 1'b1;
            if (left_val < min_reg)
                min_next = left_val;
        end

        // Fired channel: keep remainder and flag it
        if (cmd.eval_rem)
        begin
            acc_next[ch_reg] = rem_reg;
            for (int i = 0; i < MASK_W; i++)
                if (i < CHANNELS && ch_reg == CH_W'(i))
                    mask_next[i] = 1'b1;
        end

        if (cmd.calc_adv)
        begin
            if (!any_reg)
                adv_next = '0;
            else if (busy_reg < min_reg)
                adv_next = min_reg;
            else
                adv_next = busy_reg;
        end

        if (cmd.add_ch && cur_per != '0)
            acc_next[ch_reg] = sat_sum[DATA_W] ? '1 : sat_sum[DATA_W-1:0];

        if (cmd.add_time)
            time_next = time_reg + TIME_W'(adv_reg);

        if (cmd.step_ch)
            ch_next = (ch_reg == CH_W'(CHANNELS-1)) ? '0 : ch_reg + 1'b1;

        if (cmd.load_out)
        begin
            out_next.fire_mask = mask_reg;
            out_next.next_due  = min_reg;
            out_next.advance   = adv_reg;
            out_next.now_time  = time_reg;
        end
    end

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                period_reg[i] <= '0;
            for (int i = 0; i < CHANNELS; i++)
                acc_reg[i] <= '0;
            time_reg <= '0;
            ch_reg   <= '0;
            bit_reg  <= '0;
            op_reg   <= OP_PASS;
        end
        else
        begin
            if (cfg_we)
                period_reg[cfg_index] <= cfg_data;
            for (int i = 0; i < CHANNELS; i++)
                acc_reg[i] <= acc_next[i];
            time_reg <= time_next;
            ch_reg   <= ch_next;
            bit_reg  <= bit_next;
            op_reg   <= op_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        min_reg  <= min_next;
        any_reg  <= any_next;
        mask_reg <= mask_next;
        adv_reg  <= adv_next;
        busy_reg <= busy_next;
        out_reg  <= out_next;
    end

endmodule

/* src/multi_period_event_scheduler.sv */
// Sequence: a resync transaction reloads the accumulators, then loads the result.
// Scheduling pass: clear, check each channel (a due one runs a 32-step remainder
// and a write-back), pick the advance, add it per channel and to time, load result.
// Flow: one transaction at a time; the next is accepted once the result
// is in the output register, which holds it until taken.
// Reset: periods, accumulators and time counter clear to zero; no result pending.
// ============================================================================
// multi_period_event_scheduler
// Multi-channel periodic timer: fires due channels, reduces their
// accumulators modulo the period and advances active channels and a time counter.
// ============================================================================
module multi_period_event_scheduler
    import mpes_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    mpes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    mpes_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* src/mpes_checker.sv */
// ============================================================================
// mpes_checker
// Port-level checks for the scheduler, bound to the top level.
// ============================================================================
module mpes_checker
    import mpes_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input out_item_t            out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // One transaction in flight: ready drops after accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second transaction back to back");

    // Advance never undercuts the nearest due time unless nothing is active
    a_adv_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.advance >= out_data.next_due) || (out_data.next_due == '1))
        else $error("advance smaller than next due time");

    // A firing channel is active, so time must move
    a_fire_moves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.fire_mask != '0) |-> (out_data.advance != '0))
        else $error("channel fired with zero advance");

endmodule

bind multi_period_event_scheduler mpes_checker u_mpes_checker (.*);
